/* rtl/msbr_pkg.sv */
// ----------------------------------------------------------------------------
// msbr_pkg
// Shared types and constants of the msb-first bit reader: opcodes, word
// geometry of the byte store and the metadata of a read in flight.
// ----------------------------------------------------------------------------
package msbr_pkg;

   // byte and word geometry of the store
   localparam int BYTE_BITS  = 8;
   localparam int WORD_BYTES = 8;
   localparam int WORD_BITS  = WORD_BYTES * BYTE_BITS;
   localparam int LANE_W     = $clog2(WORD_BYTES);
   localparam int OFFSET_W   = $clog2(WORD_BITS);
   localparam int BYTE_SHIFT = $clog2(BYTE_BITS);
   localparam int WORD_SHIFT = $clog2(WORD_BITS);

   // field widths of the channels
   localparam int OPCODE_W    = 2;
   localparam int BIT_COUNT_W = 7;
   localparam int VALUE_W     = 64;

   // opcodes; the fourth code means nothing and is ignored
   localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd2;

   // read metadata carried next to the memory read data
   typedef struct packed {
      logic [BIT_COUNT_W-1:0] n_bits;
      logic [OFFSET_W-1:0]    offset;
      logic                   underrun;
   } read_meta_type;

endpackage

/* rtl/msbr_store.sv */
// ----------------------------------------------------------------------------
// msbr_store
// Byte store kept as a memory of 64-bit words. Bytes are written one lane at
// a time, first byte in the top lane; a read returns two consecutive words.
// ----------------------------------------------------------------------------
module msbr_store import msbr_pkg::*; #(
   parameter int ADDR_W = 5
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [LANE_W-1:0]    wr_lane,
   input  logic [BYTE_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [WORD_BITS-1:0] rd_word0,
   output logic [WORD_BITS-1:0] rd_word1
);

   localparam int WORDS = 2 ** ADDR_W;

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] word0_ff;
   logic [WORD_BITS-1:0] word1_ff;
   logic [ADDR_W-1:0]    rd_addr_next;
   logic [LANE_W-1:0]    lane_slot;

   // first byte of a word sits in the most significant lane
   assign lane_slot    = LANE_W'(WORD_BYTES - 1) - wr_lane;
   assign rd_addr_next = rd_addr + ADDR_W'(1);

   // byte-lane write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr][lane_slot * BYTE_BITS +: BYTE_BITS] <= wr_data;
      end
   end

   // two-word read, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         word0_ff <= mem[rd_addr];
         word1_ff <= mem[rd_addr_next];
      end
   end

   assign rd_word0 = word0_ff;
   assign rd_word1 = word1_ff;

endmodule

/* rtl/msbr_extract.sv */
// ----------------------------------------------------------------------------
// msbr_extract
// Aligns the read window to the bit offset, then right-justifies the
// requested bits into the result register that faces the response channel.
// ----------------------------------------------------------------------------
module msbr_extract import msbr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 s1_valid,
   input  read_meta_type        s1_meta,
   input  logic [WORD_BITS-1:0] word0,
   input  logic [WORD_BITS-1:0] word1,
   output logic                 hold,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [VALUE_W-1:0]   rsp_value,
   output logic                 rsp_underrun
);

   logic [2*WORD_BITS-1:0] window;
   logic [2*WORD_BITS-1:0] shifted;
   logic [VALUE_W-1:0]     aligned_in;
   logic [BIT_COUNT_W-1:0] drop_bits;
   logic                   s2_move;

   logic                   s2_v_ff, s2_v_in;
   logic [VALUE_W-1:0]     aligned_ff;
   logic [BIT_COUNT_W-1:0] n_ff;
   logic                   underrun_ff;
   logic                   out_v_ff, out_v_in;
   logic [VALUE_W-1:0]     value_ff;
   logic                   out_underrun_ff;

   // bring the first requested bit to the top of the window
   assign window     = {word0, word1};
   assign shifted    = window << s1_meta.offset;
   assign aligned_in = s1_meta.underrun ? '0 : shifted[2*WORD_BITS-1 -: VALUE_W];

   // stage advance and valid tracking
   assign s2_move  = s2_v_ff & (~out_v_ff | ~rsp_stall);
   assign s2_v_in  = s1_valid | (s2_v_ff & ~s2_move);
   assign out_v_in = s2_move | (out_v_ff & rsp_stall);
   assign hold     = s2_v_ff & ~s2_move;

   // number of low bits to drop when right-justifying
   assign drop_bits = BIT_COUNT_W'(VALUE_W) - n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // alignment stage payload
   always_ff @(posedge clock) begin
      if (s1_valid) begin
         aligned_ff  <= aligned_in;
         n_ff        <= s1_meta.n_bits;
         underrun_ff <= s1_meta.underrun;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s2_move) begin
         value_ff        <= aligned_ff >> drop_bits;
         out_underrun_ff <= underrun_ff;
      end
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_value    = value_ff;
   assign rsp_underrun = out_underrun_ff;

   // a new read never lands on a stage that is still held
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid |-> (!s2_v_ff || s2_move))
      else $error("read entered alignment stage while it was held");

   // an underrun result carries a zero value
   a_underrun_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_underrun) |-> (rsp_value == '0))
      else $error("underrun result with nonzero value");

endmodule

/* rtl/msb_first_bit_reader.sv */
// Read path: a read result passes the store's read register, the alignment
//   register and the output register; response stalls hold it back on the way. Loads and restarts give no result.
// Throughput: requests stall while a read sits in the store's registered
//   two-word read or while the alignment stage is held; else loads one per cycle.
// Reset: synchronous; clears loaded count, bit position and all valids.
//   The byte store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// msb_first_bit_reader
// Msb-first bit extractor over a byte store held in a word-wide memory.
// Control keeps the loaded count and bit position and issues memory reads.
// ----------------------------------------------------------------------------
module msb_first_bit_reader import msbr_pkg::*; #(
   parameter int STORE_BYTES   = 256,
   parameter int MAX_READ_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OPCODE_W-1:0]    req_opcode,
   input  logic [BYTE_BITS-1:0]   req_data_byte,
   input  logic [BIT_COUNT_W-1:0] req_bit_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_W-1:0]     rsp_value,
   output logic                   rsp_underrun
);

   localparam int COUNT_W = $clog2(STORE_BYTES + 1);
   localparam int POS_W   = $clog2(STORE_BYTES * BYTE_BITS + 1);
   localparam int WORDS   = 2 ** $clog2((STORE_BYTES + WORD_BYTES - 1) / WORD_BYTES);
   localparam int ADDR_W  = $clog2(WORDS);

   logic                   take;
   logic                   load_take;
   logic                   read_take;
   logic                   store_full;
   logic                   short_read;
   logic                   extract_hold;
   logic [BIT_COUNT_W-1:0] n_sat;
   logic [POS_W-1:0]       total_bits;
   logic [POS_W-1:0]       remaining;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [WORD_BITS-1:0]   word0;
   logic [WORD_BITS-1:0]   word1;

   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic                   s1_v_ff, s1_v_in;
   read_meta_type          meta_ff, meta_in;

   // transfer decode
   assign req_stall    = s1_v_ff | extract_hold;
   assign take         = req_valid & ~req_stall;
   assign load_take    = take & (req_opcode == OP_LOAD);
   assign read_take    = take & (req_opcode == OP_READ);

   // request length and availability check
   assign n_sat      = (req_bit_count > BIT_COUNT_W'(MAX_READ_BITS)) ?
                       BIT_COUNT_W'(MAX_READ_BITS) : req_bit_count;
   assign total_bits = POS_W'({count_ff, {BYTE_SHIFT{1'b0}}});
   assign remaining  = total_bits - pos_ff;
   assign short_read = POS_W'(n_sat) > remaining;
   assign store_full = count_ff == COUNT_W'(STORE_BYTES);

   // memory addressing
   assign wr_addr = ADDR_W'(count_ff >> LANE_W);
   assign rd_addr = ADDR_W'(pos_ff >> WORD_SHIFT);

   // next count, position and read stage
   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      s1_v_in  = read_take;
      meta_in.n_bits   = n_sat;
      meta_in.offset   = pos_ff[OFFSET_W-1:0];
      meta_in.underrun = short_read;
      if (take) begin
         case (req_opcode)
            OP_LOAD: begin
               if (!store_full) count_in = count_ff + COUNT_W'(1);
            end
            OP_READ: begin
               if (!short_read) pos_in = pos_ff + POS_W'(n_sat);
            end
            OP_RESTART: begin
               count_in = '0;
               pos_in   = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
         s1_v_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
         s1_v_ff  <= s1_v_in;
      end
   end

   // read metadata travels beside the memory read data
   always_ff @(posedge clock) begin
      if (read_take) begin
         meta_ff <= meta_in;
      end
   end

   msbr_store #(
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock    (clock),
      .wr_en    (load_take & ~store_full),
      .wr_addr  (wr_addr),
      .wr_lane  (count_ff[LANE_W-1:0]),
      .wr_data  (req_data_byte),
      .rd_en    (read_take),
      .rd_addr  (rd_addr),
      .rd_word0 (word0),
      .rd_word1 (word1)
   );

   msbr_extract u_extract (
      .clock        (clock),
      .reset        (reset),
      .s1_valid     (s1_v_ff),
      .s1_meta      (meta_ff),
      .word0        (word0),
      .word1        (word1),
      .hold         (extract_hold),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_value    (rsp_value),
      .rsp_underrun (rsp_underrun)
   );

   // position never passes the loaded bits
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= total_bits)
      else $error("bit position beyond loaded bits");

   // loaded count stays within the store
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(STORE_BYTES))
      else $error("loaded count beyond store size");

   // an underrun read leaves the position alone
   a_underrun_keeps_pos: assert property (@(posedge clock) disable iff (reset)
      (read_take && short_read) |=> $stable(pos_ff))
      else $error("underrun read moved the bit position");

endmodule
